### hdl/svsfa_pkg.sv
// ----------------------------------------------------------------------------
// svsfa_pkg
// Shared widths, mode codes and item types of the steering vector core.
// ----------------------------------------------------------------------------
`default_nettype none

package svsfa_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SPD_W   = COORD_W - 1;
    localparam int RAD_W   = 2 * DIFF_W;
    localparam int PROD_W  = DIFF_W + SPD_W;

    localparam logic [1:0] MODE_SEEK   = 2'd0;
    localparam logic [1:0] MODE_FLEE   = 2'd1;
    localparam logic [1:0] MODE_ARRIVE = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] agent_x;
        logic signed [COORD_W-1:0] agent_y;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic [SPD_W-1:0]          top_speed;
        logic [SPD_W-1:0]          slow_radius;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] steer_x;
        logic signed [COORD_W-1:0] steer_y;
        logic                      zero_length;
    } res_t;

endpackage

`default_nettype wire

### hdl/steering_vector_seek_flee_arrive_core.sv
// ----------------------------------------------------------------------------
// steering_vector_seek_flee_arrive_core
// Seek / flee / arrive steering vector, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One item per clock, busy stays low. The pipeline runs through a front end
// (offset, squares, sum), a one-bit-per-stage square root over the squared
// offset length, then one-bit-per-stage dividers for the arrive speed and for
// the per-axis scaling. done pulses for one cycle with res.
`default_nettype none

module steering_vector_seek_flee_arrive_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire svsfa_pkg::cmd_t cmd,
    output logic               done,
    output svsfa_pkg::res_t    res
);

    localparam int W   = svsfa_pkg::COORD_W;
    localparam int DW  = svsfa_pkg::DIFF_W;
    localparam int SW  = svsfa_pkg::SPD_W;
    localparam int RW  = svsfa_pkg::RAD_W;
    localparam int PW  = svsfa_pkg::PROD_W;
    localparam int RMW = DW + 3;

    typedef struct packed {
        logic [1:0]          mode;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [W-1:0]  vx;
        logic signed [W-1:0]  vy;
        logic [SW-1:0]        top;
        logic [SW-1:0]        rad;
        logic [DW-1:0]        len;
        logic                 zero;
        logic                 arr;
    } ctx_t;

    assign busy = 1'b0;

    // front: offset, squares, sum
    logic        a_vld_reg, b_vld_reg, c_vld_reg;
    ctx_t        a_ctx_reg, b_ctx_reg, c_ctx_reg, a_ctx_next;
    logic [RW-1:0] b_sqx_reg, b_sqy_reg, c_sum_reg;
    logic [DW-1:0] a_mx, a_my;

    always_comb
    begin
        a_ctx_next = '0;
        a_ctx_next.mode = cmd.mode;
        if (cmd.mode == svsfa_pkg::MODE_FLEE)
        begin
            a_ctx_next.dx = DW'(cmd.agent_x) - DW'(cmd.target_x);
            a_ctx_next.dy = DW'(cmd.agent_y) - DW'(cmd.target_y);
        end
        else
        begin
            a_ctx_next.dx = DW'(cmd.target_x) - DW'(cmd.agent_x);
            a_ctx_next.dy = DW'(cmd.target_y) - DW'(cmd.agent_y);
        end
        a_ctx_next.vx  = cmd.vel_x;
        a_ctx_next.vy  = cmd.vel_y;
        a_ctx_next.top = cmd.top_speed;
        a_ctx_next.rad = cmd.slow_radius;
    end

    assign a_mx = a_ctx_reg.dx[DW-1] ? DW'(-a_ctx_reg.dx) : DW'(a_ctx_reg.dx);
    assign a_my = a_ctx_reg.dy[DW-1] ? DW'(-a_ctx_reg.dy) : DW'(a_ctx_reg.dy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ctx_reg <= a_ctx_next;
        b_ctx_reg <= a_ctx_reg;
        b_sqx_reg <= RW'(a_mx) * RW'(a_mx);
        b_sqy_reg <= RW'(a_my) * RW'(a_my);
        c_ctx_reg <= b_ctx_reg;
        c_sum_reg <= b_sqx_reg + b_sqy_reg;
    end

    // square root, one root bit per stage
    logic          sq_vld [0:DW];
    ctx_t          sq_ctx [0:DW];
    logic [RW-1:0] sq_rad [0:DW];
    logic [RMW-1:0] sq_rem [0:DW];
    logic [DW-1:0] sq_root [0:DW];

    assign sq_vld[0]  = c_vld_reg;
    assign sq_ctx[0]  = c_ctx_reg;
    assign sq_rad[0]  = c_sum_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    genvar k;
    generate
        for (k = 0; k < DW; k++)
        begin : g_sqrt
            logic [RMW-1:0] sh;
            logic [RMW-1:0] trial;
            always_comb
            begin
                sh    = {sq_rem[k][RMW-3:0], sq_rad[k][RW-1-2*k -: 2]};
                trial = {1'b0, sq_root[k], 2'b01};
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_vld[k+1] <= 1'b0;
                else
                    sq_vld[k+1] <= sq_vld[k];
            end
            always_ff @(posedge clk)
            begin
                sq_ctx[k+1] <= sq_ctx[k];
                sq_rad[k+1] <= sq_rad[k];
                if (sh >= trial)
                begin
                    sq_rem[k+1]  <= sh - trial;
                    sq_root[k+1] <= {sq_root[k][DW-2:0], 1'b1};
                end
                else
                begin
                    sq_rem[k+1]  <= sh;
                    sq_root[k+1] <= {sq_root[k][DW-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // length known: arrive decision and top * len
    logic          d_vld_reg;
    ctx_t          d_ctx_reg, d_ctx_next;
    logic [PW-1:0] d_prod_reg;

    always_comb
    begin
        d_ctx_next      = sq_ctx[DW];
        d_ctx_next.len  = sq_root[DW];
        d_ctx_next.zero = (sq_root[DW] == '0);
        d_ctx_next.arr  = (sq_ctx[DW].mode == svsfa_pkg::MODE_ARRIVE)
                          && (sq_ctx[DW].rad != '0)
                          && (sq_root[DW] < DW'(sq_ctx[DW].rad));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else
            d_vld_reg <= sq_vld[DW];
    end

    always_ff @(posedge clk)
    begin
        d_ctx_reg  <= d_ctx_next;
        d_prod_reg <= PW'(sq_ctx[DW].top) * PW'(sq_root[DW]);
    end

    // arrive speed divider: top * len / radius
    logic          sd_vld [0:SW];
    ctx_t          sd_ctx [0:SW];
    logic [PW-1:0] sd_num [0:SW];
    logic [SW-1:0] sd_rem [0:SW];
    logic [SW-1:0] sd_q   [0:SW];

    assign sd_vld[0] = d_vld_reg;
    assign sd_ctx[0] = d_ctx_reg;
    assign sd_num[0] = d_prod_reg;
    assign sd_rem[0] = SW'(d_prod_reg[PW-1:SW]);
    assign sd_q[0]   = '0;

    generate
        for (k = 0; k < SW; k++)
        begin : g_sdiv
            logic [SW:0] t;
            assign t = {sd_rem[k], sd_num[k][SW-1-k]};
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sd_vld[k+1] <= 1'b0;
                else
                    sd_vld[k+1] <= sd_vld[k];
            end
            always_ff @(posedge clk)
            begin
                sd_ctx[k+1] <= sd_ctx[k];
                sd_num[k+1] <= sd_num[k];
                if (t >= {1'b0, sd_ctx[k].rad})
                begin
                    sd_rem[k+1] <= SW'(t - {1'b0, sd_ctx[k].rad});
                    sd_q[k+1]   <= {sd_q[k][SW-2:0], 1'b1};
                end
                else
                begin
                    sd_rem[k+1] <= SW'(t);
                    sd_q[k+1]   <= {sd_q[k][SW-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // per-axis numerators |d| * speed
    logic          e_vld_reg;
    ctx_t          e_ctx_reg;
    logic [PW-1:0] e_px_reg, e_py_reg;
    logic [SW-1:0] e_speed;
    logic [DW-1:0] e_mx, e_my;

    assign e_speed = sd_ctx[SW].arr ? sd_q[SW] : sd_ctx[SW].top;
    assign e_mx = sd_ctx[SW].dx[DW-1] ? DW'(-sd_ctx[SW].dx) : DW'(sd_ctx[SW].dx);
    assign e_my = sd_ctx[SW].dy[DW-1] ? DW'(-sd_ctx[SW].dy) : DW'(sd_ctx[SW].dy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= sd_vld[SW];
    end

    always_ff @(posedge clk)
    begin
        e_ctx_reg <= sd_ctx[SW];
        e_px_reg  <= PW'(e_mx) * PW'(e_speed);
        e_py_reg  <= PW'(e_my) * PW'(e_speed);
    end

    // per-axis dividers by len
    logic          ad_vld [0:SW];
    ctx_t          ad_ctx [0:SW];
    logic [PW-1:0] ad_nx  [0:SW];
    logic [PW-1:0] ad_ny  [0:SW];
    logic [DW-1:0] ad_rx  [0:SW];
    logic [DW-1:0] ad_ry  [0:SW];
    logic [SW-1:0] ad_qx  [0:SW];
    logic [SW-1:0] ad_qy  [0:SW];

    assign ad_vld[0] = e_vld_reg;
    assign ad_ctx[0] = e_ctx_reg;
    assign ad_nx[0]  = e_px_reg;
    assign ad_ny[0]  = e_py_reg;
    assign ad_rx[0]  = e_px_reg[PW-1:SW];
    assign ad_ry[0]  = e_py_reg[PW-1:SW];
    assign ad_qx[0]  = '0;
    assign ad_qy[0]  = '0;

    generate
        for (k = 0; k < SW; k++)
        begin : g_adiv
            logic [DW:0] tx;
            logic [DW:0] ty;
            logic [DW:0] dv;
            assign tx = {ad_rx[k], ad_nx[k][SW-1-k]};
            assign ty = {ad_ry[k], ad_ny[k][SW-1-k]};
            assign dv = {1'b0, ad_ctx[k].len};
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ad_vld[k+1] <= 1'b0;
                else
                    ad_vld[k+1] <= ad_vld[k];
            end
            always_ff @(posedge clk)
            begin
                ad_ctx[k+1] <= ad_ctx[k];
                ad_nx[k+1]  <= ad_nx[k];
                ad_ny[k+1]  <= ad_ny[k];
                if (tx >= dv)
                begin
                    ad_rx[k+1] <= DW'(tx - dv);
                    ad_qx[k+1] <= {ad_qx[k][SW-2:0], 1'b1};
                end
                else
                begin
                    ad_rx[k+1] <= DW'(tx);
                    ad_qx[k+1] <= {ad_qx[k][SW-2:0], 1'b0};
                end
                if (ty >= dv)
                begin
                    ad_ry[k+1] <= DW'(ty - dv);
                    ad_qy[k+1] <= {ad_qy[k][SW-2:0], 1'b1};
                end
                else
                begin
                    ad_ry[k+1] <= DW'(ty);
                    ad_qy[k+1] <= {ad_qy[k][SW-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // sign, minus velocity, saturate
    ctx_t                f_ctx;
    logic signed [DW-1:0] f_desx, f_desy, f_sx, f_sy;
    logic signed [W-1:0]  f_ox, f_oy;
    svsfa_pkg::res_t     res_next;
    logic                done_reg;
    svsfa_pkg::res_t     res_reg;

    always_comb
    begin
        f_ctx  = ad_ctx[SW];
        f_desx = f_ctx.dx[DW-1] ? -$signed(DW'(ad_qx[SW])) : $signed(DW'(ad_qx[SW]));
        f_desy = f_ctx.dy[DW-1] ? -$signed(DW'(ad_qy[SW])) : $signed(DW'(ad_qy[SW]));
        f_sx   = f_desx - DW'(f_ctx.vx);
        f_sy   = f_desy - DW'(f_ctx.vy);
        if (f_sx[DW-1] != f_sx[DW-2])
            f_ox = f_sx[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            f_ox = f_sx[W-1:0];
        if (f_sy[DW-1] != f_sy[DW-2])
            f_oy = f_sy[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            f_oy = f_sy[W-1:0];
        res_next.zero_length = f_ctx.zero;
        res_next.steer_x     = f_ctx.zero ? '0 : f_ox;
        res_next.steer_y     = f_ctx.zero ? '0 : f_oy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ad_vld[SW];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire
